FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check, disabled while reset is asserted.
`define RLR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define RLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `RLR_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

FILE: hdl/rlr_pkg.sv
// ----------------------------------------------------------------------------
// rlr_pkg
// Types and constants for the lossy record ring with commit.
// ----------------------------------------------------------------------------
package rlr_pkg;

  localparam int CAPACITY    = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int META_W      = 16;
  localparam int REC_W       = META_W + 64 + 64;
  localparam int CFG_ADDR_W  = 3;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FETCH  = 2'd1,
    FUNC_ACCEPT = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NO_DATA     = 2'd1,
    STATUS_NOT_ENABLED = 2'd2,
    STATUS_IGNORED     = 2'd3
  } status_e;

  // register index, taken from paddr[2]
  localparam logic REG_ENABLED        = 1'b0;
  localparam logic REG_WRITES_BLOCKED = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rec_type;
    logic [7:0]  rec_len;
    logic [63:0] rec_time;
    logic [63:0] rec_data;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  out_type;
    logic [7:0]  out_len;
    logic [63:0] out_time;
    logic [63:0] out_data;
    logic        dropped;
  } out_item_t;

  typedef struct packed {
    logic enabled;
    logic writes_blocked;
  } cfg_t;

  // command handed from front to back; slot address travels beside it
  typedef struct packed {
    logic             wr;
    logic             rd;
    status_e          status;
    logic             dropped;
    logic [REC_W-1:0] rec;
  } cmd_t;

endpackage

FILE: hdl/rlr_front.sv
// ----------------------------------------------------------------------------
// rlr_front
// Accepts items, owns the ring counters and turns each item into a command.
// ----------------------------------------------------------------------------
module rlr_front #(
  parameter int CAPACITY = rlr_pkg::CAPACITY,
  localparam int SlotW   = $clog2(CAPACITY)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rlr_pkg::in_item_t in_data_i,
  input  rlr_pkg::cfg_t     cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output rlr_pkg::cmd_t     cmd_o,
  output logic [SlotW-1:0]  addr_o
);

  localparam int SumW = SlotW + 1;
  localparam logic [SumW-1:0] CapS  = SumW'(CAPACITY);
  // slot offset of (w - CAPACITY) mod 2^32 when w < CAPACITY
  localparam logic [SumW-1:0] WrapK = SumW'((64'd1 << 32) % CAPACITY);

  logic [31:0]      wr_cnt_q, wr_cnt_d, rd_cnt_q, rd_cnt_d;
  logic [SlotW-1:0] wr_slot_q, wr_slot_d, rd_slot_q, rd_slot_d;
  logic             pend_q, pend_d;
  logic [31:0]      pending;
  logic [SumW-1:0]  wrap_sum;
  logic [SlotW-1:0] wrap_slot;
  logic             accept;

  function automatic logic [SlotW-1:0] slot_inc(logic [31:0] cnt, logic [SlotW-1:0] slot);
    logic [SlotW-1:0] res;
    if (cnt == '1 || slot == SlotW'(CAPACITY - 1)) begin
      res = '0;
    end else begin
      res = slot + SlotW'(1);
    end
    return res;
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign pending    = wr_cnt_q - rd_cnt_q;
  assign wrap_sum   = {1'b0, wr_slot_q} + WrapK;
  assign wrap_slot  = (wrap_sum >= CapS) ? SlotW'(wrap_sum - CapS) : SlotW'(wrap_sum);

  always_comb begin
    wr_cnt_d  = wr_cnt_q;
    rd_cnt_d  = rd_cnt_q;
    wr_slot_d = wr_slot_q;
    rd_slot_d = rd_slot_q;
    pend_d    = pend_q;
    cmd_o         = '0;
    cmd_o.status  = rlr_pkg::STATUS_OK;
    cmd_o.rec     = {in_data_i.rec_type, in_data_i.rec_len,
                     in_data_i.rec_time, in_data_i.rec_data};
    addr_o        = rd_slot_q;
    unique case (rlr_pkg::func_e'(in_data_i.func))
      rlr_pkg::FUNC_INSERT: begin
        if (!cfg_i.enabled || cfg_i.writes_blocked) begin
          cmd_o.status = rlr_pkg::STATUS_IGNORED;
        end else begin
          cmd_o.wr  = 1'b1;
          addr_o    = wr_slot_q;
          wr_cnt_d  = wr_cnt_q + 32'd1;
          wr_slot_d = slot_inc(wr_cnt_q, wr_slot_q);
        end
      end
      rlr_pkg::FUNC_FETCH: begin
        if (!cfg_i.enabled) begin
          cmd_o.status = rlr_pkg::STATUS_NOT_ENABLED;
        end else if (pending == '0) begin
          cmd_o.status = rlr_pkg::STATUS_NO_DATA;
        end else begin
          cmd_o.rd = 1'b1;
          pend_d   = 1'b1;
          if (pending > 32'(CAPACITY)) begin
            // overrun: skip to the oldest record still held
            cmd_o.dropped = 1'b1;
            rd_cnt_d  = wr_cnt_q - 32'(CAPACITY);
            rd_slot_d = (wr_cnt_q >= 32'(CAPACITY)) ? wr_slot_q : wrap_slot;
            addr_o    = rd_slot_d;
          end
        end
      end
      rlr_pkg::FUNC_ACCEPT: begin
        if (pend_q) begin
          rd_cnt_d  = rd_cnt_q + 32'd1;
          rd_slot_d = slot_inc(rd_cnt_q, rd_slot_q);
          pend_d    = 1'b0;
        end
      end
      rlr_pkg::FUNC_CLEAR: begin
        wr_cnt_d  = '0;
        rd_cnt_d  = '0;
        wr_slot_d = '0;
        rd_slot_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q  <= '0;
      rd_cnt_q  <= '0;
      wr_slot_q <= '0;
      rd_slot_q <= '0;
      pend_q    <= 1'b0;
    end else if (accept) begin
      wr_cnt_q  <= wr_cnt_d;
      rd_cnt_q  <= rd_cnt_d;
      wr_slot_q <= wr_slot_d;
      rd_slot_q <= rd_slot_d;
      pend_q    <= pend_d;
    end
  end

endmodule

FILE: hdl/rlr_queue.sv
// ----------------------------------------------------------------------------
// rlr_queue
// Small command queue between front and back.
// ----------------------------------------------------------------------------
module rlr_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = rlr_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

FILE: hdl/rlr_back.sv
// ----------------------------------------------------------------------------
// rlr_back
// Executes commands against the record memory and holds the result beat.
// ----------------------------------------------------------------------------
module rlr_back #(
  parameter int CAPACITY = rlr_pkg::CAPACITY,
  localparam int SlotW   = $clog2(CAPACITY)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  rlr_pkg::cmd_t      cmd_i,
  input  logic [SlotW-1:0]   addr_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rlr_pkg::out_item_t out_data_o
);

  localparam int RecW = rlr_pkg::REC_W;

  logic [RecW-1:0]  mem_q [CAPACITY];
  logic [RecW-1:0]  rdata_q;
  logic             res_valid_q;
  rlr_pkg::status_e res_status_q;
  logic             res_rd_q;
  logic             res_dropped_q;

  // read data only moves on a pop, so it holds while the result is stalled
  assign pop_o = !empty_i && (!res_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.wr) begin
      mem_q[addr_i] <= cmd_i.rec;
    end
    if (pop_o && cmd_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_status_q  <= cmd_i.status;
      res_rd_q      <= cmd_i.rd;
      res_dropped_q <= cmd_i.dropped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pop_o) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = res_valid_q;

  always_comb begin
    out_data_o        = '0;
    out_data_o.status = res_status_q;
    if (res_rd_q) begin
      out_data_o.out_type = rdata_q[RecW-1 -: 8];
      out_data_o.out_len  = rdata_q[RecW-9 -: 8];
      out_data_o.out_time = rdata_q[127:64];
      out_data_o.out_data = rdata_q[63:0];
      out_data_o.dropped  = res_dropped_q;
    end
  end

endmodule

FILE: hdl/lossy_record_ring_with_commit.sv
// ----------------------------------------------------------------------------
// lossy_record_ring_with_commit
// Overwriting record ring with provisional fetch and commit.
//
//   channel   direction   handshake                payload
//   in        in          in_valid_i / in_ready_o   in_item_t
//   out       out         out_valid_o / out_ready_i out_item_t
//   cfg       in          APB (psel..pready)        enabled, writes_blocked
//
// One item accepted per cycle while the queue has room; its result beat is
// registered after the queue write and then the registered memory read.
// The front decides each item from the counters in its accept cycle; the back
// does one memory access per command, so the memory port sets the rate.
// A two-entry queue lets the back stall on out_ready_i; in_ready_o drops when
// it is full. Reset clears counters and control only; no clearing pass, the
// record memory is undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lossy_record_ring_with_commit #(
  parameter int CAPACITY = rlr_pkg::CAPACITY
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rlr_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rlr_pkg::out_item_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rlr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int SlotW = $clog2(CAPACITY);
  localparam int QW    = SlotW + $bits(rlr_pkg::cmd_t);

  rlr_pkg::cfg_t    cfg_q;
  logic             cfg_we;
  logic             q_push, q_pop, q_full, q_empty;
  rlr_pkg::cmd_t    f_cmd, b_cmd;
  logic [SlotW-1:0] f_addr, b_addr;
  logic [QW-1:0]    q_out;
  logic             res_ok, res_blank;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        rlr_pkg::REG_ENABLED:        cfg_q.enabled        <= pwdata[0];
        rlr_pkg::REG_WRITES_BLOCKED: cfg_q.writes_blocked <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      rlr_pkg::REG_ENABLED:        prdata[0] = cfg_q.enabled;
      rlr_pkg::REG_WRITES_BLOCKED: prdata[0] = cfg_q.writes_blocked;
    endcase
  end

  rlr_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .full_i     (q_full),
    .push_o     (q_push),
    .cmd_o      (f_cmd),
    .addr_o     (f_addr)
  );

  rlr_queue #(.DATA_W(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_addr, f_cmd}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign b_addr = q_out[QW-1 -: SlotW];
  assign b_cmd  = rlr_pkg::cmd_t'(q_out[$bits(rlr_pkg::cmd_t)-1:0]);

  rlr_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (b_cmd),
    .addr_i      (b_addr),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign res_ok    = (out_data_o.status == rlr_pkg::STATUS_OK);
  assign res_blank = (out_data_o.out_time == '0) && (out_data_o.out_data == '0);

  `RLR_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, q_push && !q_pop, !q_empty)
  `RLR_ASSERT(a_pop_nonempty, clk_i, rst_ni, q_pop |-> !q_empty)
  `RLR_ASSERT(a_drop_ok, clk_i, rst_ni, out_valid_o && out_data_o.dropped |-> res_ok)
  `RLR_ASSERT(a_other_zero, clk_i, rst_ni, out_valid_o && !res_ok |-> res_blank)

endmodule

FILE: tb/sv/ring_check_pkg.sv
// ----------------------------------------------------------------------------
// ring_check_pkg
// Scoreboard for the record ring: tracks counters, slots and the fetch
// commit flag, predicts the result beat of each accepted command and checks
// the result beats that come back.
// ----------------------------------------------------------------------------
package ring_check_pkg;

  import rlr_pkg::*;

  localparam int MAX_PRINTED = 200;

  class ring_scoreboard;

    bit              enabled;
    bit              writes_blocked;
    bit [31:0]       wr_count;
    bit [31:0]       rd_count;
    bit              fetch_armed;
    bit [15:0]       meta_slot    [CAPACITY];
    bit [63:0]       time_slot    [CAPACITY];
    bit [63:0]       data_slot    [CAPACITY];
    bit              slot_written [CAPACITY];

    out_item_t       awaited_results [$];

    int              failures;
    int              beats_in;
    int              effective_beats;
    int              results_checked;
    int              records_fetched;
    int              overrun_fetches;

    function void set_reg(logic idx, logic val);
      if (idx == REG_ENABLED) begin
        enabled = val;
      end else begin
        writes_blocked = val;
      end
    endfunction

    // true when a fetch issued now would land on a slot never written
    function bit fetch_reads_unwritten();
      bit [31:0] backlog;
      bit [31:0] head;
      backlog = wr_count - rd_count;
      if (!enabled || backlog == 0) return 1'b0;
      head = (backlog > CAPACITY) ? wr_count - CAPACITY : rd_count;
      return !slot_written[head % CAPACITY];
    endfunction

    function out_item_t predict_record_result(in_item_t it);
      out_item_t   res;
      bit [31:0]   backlog;
      int unsigned slot;
      res = '0;
      case (it.func)
        FUNC_INSERT: begin
          if (!enabled || writes_blocked) begin
            res.status = STATUS_IGNORED;
          end else begin
            slot = wr_count % CAPACITY;
            meta_slot[slot]    = {it.rec_type, it.rec_len};
            time_slot[slot]    = it.rec_time;
            data_slot[slot]    = it.rec_data;
            slot_written[slot] = 1'b1;
            wr_count++;
          end
        end
        FUNC_FETCH: begin
          backlog = wr_count - rd_count;
          if (!enabled) begin
            res.status = STATUS_NOT_ENABLED;
          end else if (backlog == 0) begin
            res.status = STATUS_NO_DATA;
          end else begin
            // overrun: skip to the oldest record still held
            if (backlog > CAPACITY) begin
              rd_count    = wr_count - CAPACITY;
              res.dropped = 1'b1;
              overrun_fetches++;
            end
            slot         = rd_count % CAPACITY;
            res.out_type = meta_slot[slot][15:8];
            res.out_len  = meta_slot[slot][7:0];
            res.out_time = time_slot[slot];
            res.out_data = data_slot[slot];
            fetch_armed  = 1'b1;
            records_fetched++;
          end
        end
        FUNC_ACCEPT: begin
          if (fetch_armed) begin
            rd_count++;
            fetch_armed = 1'b0;
          end
        end
        default: begin
          // clear ignores the enables and keeps the commit flag
          wr_count = '0;
          rd_count = '0;
        end
      endcase
      return res;
    endfunction

    function void note_beat(in_item_t it);
      out_item_t res;
      res = predict_record_result(it);
      awaited_results.push_back(res);
      beats_in++;
      if (!(res.status inside {STATUS_IGNORED, STATUS_NOT_ENABLED})) effective_beats++;
    endfunction

    task report(string what);
      failures++;
      if (failures <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_beat(out_item_t got);
      out_item_t exp;
      if (awaited_results.size() == 0) begin
        report("result beat with no command waiting");
        return;
      end
      exp = awaited_results.pop_front();
      results_checked++;
      if (got.status !== exp.status)
        report($sformatf("status got %0d exp %0d", got.status, exp.status));
      if (got.out_type !== exp.out_type)
        report($sformatf("out_type got %h exp %h", got.out_type, exp.out_type));
      if (got.out_len !== exp.out_len)
        report($sformatf("out_len got %h exp %h", got.out_len, exp.out_len));
      if (got.out_time !== exp.out_time)
        report($sformatf("out_time got %h exp %h", got.out_time, exp.out_time));
      if (got.out_data !== exp.out_data)
        report($sformatf("out_data got %h exp %h", got.out_data, exp.out_data));
      if (got.dropped !== exp.dropped)
        report($sformatf("dropped got %b exp %b", got.dropped, exp.dropped));
    endtask

  endclass

endpackage

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the lossy record ring: a directed pass over the disabled,
// blocked, commit, clear and counter-wrap cases, then random command
// sequences under three idling mixes, a long insert burst that overruns the
// ring and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import rlr_pkg::*;
  import ring_check_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  ring_scoreboard sb;
  int             tx_idle_pct;
  int             rx_idle_pct;
  int             rx_hold;
  int             cycle_count;

  lossy_record_ring_with_commit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a counted hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_beat(out_data_o);
  end

  function automatic in_item_t make_record(logic [1:0] f, logic [7:0] ty, logic [7:0] ln,
                                           logic [63:0] tm, logic [63:0] dt);
    in_item_t it;
    it.func     = f;
    it.rec_type = ty;
    it.rec_len  = ln;
    it.rec_time = tm;
    it.rec_data = dt;
    return it;
  endfunction

  function automatic in_item_t rand_record(logic [1:0] f);
    return make_record(f, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                       {$urandom, $urandom});
  endfunction

  // one input beat; called just after a rising edge
  task automatic send_item(in_item_t it);
    // a fetch onto a never-written slot is steered into a clear
    if (it.func == FUNC_FETCH && sb.fetch_reads_unwritten()) it.func = FUNC_CLEAR;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_item(make_record(FUNC_INSERT, 8'hFF, 8'hFF, '1, '1));  // disabled: ignored
    send_item(rand_record(FUNC_FETCH));                          // not enabled
    send_item(rand_record(FUNC_ACCEPT));                         // nothing armed
    send_item(rand_record(FUNC_CLEAR));
    quiesce();
    write_reg(REG_ENABLED, 1'b1);
    send_item(rand_record(FUNC_FETCH));                          // empty
    send_item(make_record(FUNC_INSERT, 8'hFF, 8'hFF, '1, '1));
    send_item(make_record(FUNC_INSERT, 8'h00, 8'h00, '0, '0));
    send_item(rand_record(FUNC_INSERT));
    send_item(rand_record(FUNC_FETCH));
    send_item(rand_record(FUNC_FETCH));                          // not consumed
    send_item(rand_record(FUNC_ACCEPT));
    send_item(rand_record(FUNC_ACCEPT));
    send_item(rand_record(FUNC_FETCH));
    send_item(rand_record(FUNC_ACCEPT));
    send_item(rand_record(FUNC_FETCH));
    send_item(rand_record(FUNC_ACCEPT));
    send_item(rand_record(FUNC_FETCH));
    quiesce();
    write_reg(REG_WRITES_BLOCKED, 1'b1);
    send_item(rand_record(FUNC_INSERT));
    send_item(rand_record(FUNC_FETCH));
    quiesce();
    write_reg(REG_WRITES_BLOCKED, 1'b0);
    // armed fetch survives a clear; the accept then wraps read past write
    send_item(rand_record(FUNC_INSERT));
    send_item(rand_record(FUNC_FETCH));
    send_item(rand_record(FUNC_CLEAR));
    send_item(rand_record(FUNC_ACCEPT));
    send_item(rand_record(FUNC_FETCH));
    send_item(rand_record(FUNC_ACCEPT));
    send_item(rand_record(FUNC_FETCH));
    send_item(rand_record(FUNC_ACCEPT));
    send_item(rand_record(FUNC_CLEAR));
  endtask

  task automatic run_phase(int budget, bit overrun_burst);
    int base;
    int pick;
    int n;
    base = sb.effective_beats;
    if (overrun_burst) begin
      quiesce();
      write_reg(REG_ENABLED, 1'b1);
      write_reg(REG_WRITES_BLOCKED, 1'b0);
      n = $urandom_range(260, 290);
      repeat (n) send_item(rand_record(FUNC_INSERT));
    end
    while (sb.effective_beats - base < budget) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        n = $urandom_range(1, 12);
        repeat (n) send_item(rand_record(FUNC_INSERT));
      end else if (pick < 65) begin
        send_item(rand_record(FUNC_FETCH));
        if ($urandom_range(3) == 0) send_item(rand_record(FUNC_FETCH));
        send_item(rand_record(FUNC_ACCEPT));
      end else if (pick < 75) begin
        send_item(rand_record(FUNC_FETCH));
      end else if (pick < 83) begin
        send_item(rand_record(FUNC_ACCEPT));
      end else if (pick < 88) begin
        send_item(rand_record(FUNC_CLEAR));
      end else if (pick < 95) begin
        send_item(rand_record(2'($urandom_range(3))));
      end else begin
        quiesce();
        write_reg(REG_ENABLED, $urandom_range(3) != 0);
        write_reg(REG_WRITES_BLOCKED, $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rx_hold     = 0;
    tx_idle_pct = 33;
    rx_idle_pct = 64;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_phase(50, 1'b0);

    quiesce();
    tx_idle_pct = 64;
    rx_idle_pct = 33;
    run_phase(300, 1'b1);

    quiesce();
    write_reg(REG_ENABLED, 1'b1);
    write_reg(REG_WRITES_BLOCKED, 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold     = HOLD_CYCLES;  // input keeps offering while the output is held
    run_phase(50, 1'b0);

    quiesce();
    $display("Covered %0d command beats, %0d result beats checked, %0d records fetched",
             sb.beats_in, sb.results_checked, sb.records_fetched);
    $display("Overrun fetches %0d, failures %0d", sb.overrun_fetches, sb.failures);
    if (sb.failures == 0 && sb.awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rlr_pkg.sv
hdl/rlr_front.sv
hdl/rlr_queue.sv
hdl/rlr_back.sv
hdl/lossy_record_ring_with_commit.sv
tb/sv/ring_check_pkg.sv
tb/sv/tb_top.sv
